// File: design/isort_pkg.sv
package isort_pkg;

   localparam int unsigned DataWidthDefault = 32;
   localparam int unsigned MaxItemsDefault  = 64;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;     // place the broadcast key into the sorted row
      logic shift_out;  // move the row one cell toward the output end
   } sort_cmd_type;

endpackage

// File: design/isort_cell.sv
module isort_cell #(
   parameter int unsigned DATA_WIDTH = isort_pkg::DataWidthDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  isort_pkg::sort_cmd_type      cmd,
   input  logic signed [DATA_WIDTH-1:0] key,
   input  logic signed [DATA_WIDTH-1:0] left_value,
   input  logic                         left_valid,
   input  logic                         left_gt,
   input  logic signed [DATA_WIDTH-1:0] right_value,
   input  logic                         right_valid,
   output logic signed [DATA_WIDTH-1:0] value,
   output logic                         valid,
   output logic                         gt
);
   import isort_pkg::*;

   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic                         valid_ff, valid_in;
   logic                         take;

   // strictly greater: equal keys stay behind earlier arrivals
   assign gt   = valid_ff && (value_ff > key);
   assign take = cmd.insert && (gt || (!valid_ff && left_valid));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.shift_out) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (take) begin
         value_in = left_gt ? left_value : key;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// File: design/insertion_sorter.sv
// Streaming stable insertion sorter. Signed values arrive one transaction per
// clock on req_ and are kept in ascending order in a row of MAX_ITEMS cells;
// each incoming value is compared against every cell at once and the cells
// above the insertion point shift up by one, so each value is inserted as it
// arrives and req_ready stays high while collecting. Equal values keep arrival
// order. A value with req_last set is inserted first, then the whole row
// drains out of cell 0 at one transaction per cycle while rsp_ready is high,
// with rsp_end_of_set on the final one; req_ready is low during the drain.
// Values arriving while all cells are occupied are dropped and rsp_overflow
// is set on every result of that set. After reset the row is empty and ready
// at once.
module insertion_sorter #(
   parameter int unsigned DATA_WIDTH = isort_pkg::DataWidthDefault,
   parameter int unsigned MAX_ITEMS  = isort_pkg::MaxItemsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                         rsp_end_of_set,
   output logic                         rsp_overflow
);
   import isort_pkg::*;

   // cell outputs; index 0 is the smallest value and the output end
   logic signed [DATA_WIDTH-1:0] cell_value [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]         cell_valid;
   logic [MAX_ITEMS-1:0]         cell_gt;

   logic         draining_ff, draining_in;
   logic         dropped_ff,  dropped_in;
   logic         req_take;
   logic         rsp_take;
   logic         full;
   sort_cmd_type cmd;

   // row is full once the top cell holds a value
   assign full     = cell_valid[MAX_ITEMS-1];
   assign req_ready = !draining_ff;
   assign req_take  = req_valid && req_ready;

   // cell 0 is the output register; it only shows data while draining
   assign rsp_valid        = draining_ff && cell_valid[0];
   assign rsp_sorted_value = cell_value[0];
   assign rsp_end_of_set   = !cell_valid[1];
   assign rsp_overflow     = dropped_ff;
   assign rsp_take         = rsp_valid && rsp_ready;

   assign cmd.insert    = req_take && !full;
   assign cmd.shift_out = rsp_take;

   always_comb begin
      draining_in = draining_ff;
      dropped_in  = dropped_ff;
      if (req_take) begin
         if (full) begin
            dropped_in = 1'b1;
         end
         if (req_last) begin
            draining_in = 1'b1;
         end
      end
      // final transaction of the set empties the row and clears the draining and overflow flags
      if (rsp_take && rsp_end_of_set) begin
         draining_in = 1'b0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         dropped_ff  <= dropped_in;
      end
   end

   // systolic row: each cell sees its lower and upper neighbor
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] lv, rv;
      logic                         lvalid, lgt, rvalid;

      if (i == 0) begin : g_first
         assign lv     = '0;
         assign lvalid = 1'b1;
         assign lgt    = 1'b0;
      end else begin : g_mid
         assign lv     = cell_value[i-1];
         assign lvalid = cell_valid[i-1];
         assign lgt    = cell_gt[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_top
         assign rv     = '0;
         assign rvalid = 1'b0;
      end else begin : g_below
         assign rv     = cell_value[i+1];
         assign rvalid = cell_valid[i+1];
      end

      isort_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key         (req_value),
         .left_value  (lv),
         .left_valid  (lvalid),
         .left_gt     (lgt),
         .right_value (rv),
         .right_valid (rvalid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .gt          (cell_gt[i])
      );
   end

endmodule

// File: design/isort_checker.sv
module isort_checker #(
   parameter int unsigned DATA_WIDTH = isort_pkg::DataWidthDefault
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_last,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   input logic                         rsp_end_of_set,
   input logic                         rsp_overflow
);
   import isort_pkg::*;

   // no intake while a set is draining
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while results pending");

   // a last-marked transaction always starts output next cycle
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid)
      else $error("no result after last");

   // end of set returns to collecting
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_end_of_set |=> !rsp_valid && req_ready)
      else $error("output continued past end of set");

   // mid-set results continue with the same overflow state
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_end_of_set
      |=> rsp_valid && (rsp_overflow == $past(rsp_overflow)))
      else $error("set broken or overflow changed mid-set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value))
      else $error("stalled result changed");

endmodule

bind insertion_sorter isort_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_isort_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_end_of_set   (rsp_end_of_set),
   .rsp_overflow     (rsp_overflow)
);
